FILE: hdl/wtrl_pkg.sv
// ----------------------------------------------------------------------------
// wtrl_pkg
// Shared types and constants for the windowed token rate limiter.
// ----------------------------------------------------------------------------
package wtrl_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNAVAIL = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  // input word kind
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_TAKE = 1'b1
  } req_t;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_AMOUNT   = 2'd1;

  // field widths on the ports
  localparam int AMOUNT_BITS    = 16;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 16;

  // register reset values
  localparam int RST_INTERVAL = 1000;
  localparam int RST_AMOUNT   = 100;

  // outcome of one evaluation
  typedef struct packed {
    logic    has_result;
    status_t status;
  } eval_res_t;

endpackage

FILE: hdl/wtrl_in_reg.sv
// ----------------------------------------------------------------------------
// wtrl_in_reg
// Input register stage: holds one accepted word until the evaluator consumes it.
// ----------------------------------------------------------------------------
module wtrl_in_reg import wtrl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req,
  input  logic [AMOUNT_BITS-1:0] in_amount,
  input  logic                   in_may_wait,
  input  logic                   consume,
  output logic                   s1_valid,
  output req_t                   s1_req,
  output logic [AMOUNT_BITS-1:0] s1_amount,
  output logic                   s1_may_wait
);

  logic                   valid_r, valid_nxt;
  req_t                   req_r;
  logic [AMOUNT_BITS-1:0] amount_r;
  logic                   may_wait_r;
  logic                   load;

  // free, or emptied in this same cycle
  assign in_ready = !valid_r || consume;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r      <= req_t'(in_req);
      amount_r   <= in_amount;
      may_wait_r <= in_may_wait;
    end
  end

  assign s1_valid    = valid_r;
  assign s1_req      = req_r;
  assign s1_amount   = amount_r;
  assign s1_may_wait = may_wait_r;

endmodule

FILE: hdl/wtrl_eval.sv
// ----------------------------------------------------------------------------
// wtrl_eval
// Single-pass evaluation of a tick or take against the bucket state.
// ----------------------------------------------------------------------------
module wtrl_eval import wtrl_pkg::*; #(
  parameter int TOKEN_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  req_t                  req,
  input  logic [TOKEN_BITS-1:0] amount,
  input  logic                  may_wait,
  input  logic [TOKEN_BITS-1:0] token_count,
  input  logic [TIME_BITS-1:0]  ticks,
  input  logic [TOKEN_BITS-1:0] remainder,
  input  logic                  waiting,
  input  logic [TIME_BITS-1:0]  interval,
  input  logic [TOKEN_BITS-1:0] refill_amount,
  output logic [TOKEN_BITS-1:0] token_count_nxt,
  output logic [TIME_BITS-1:0]  ticks_nxt,
  output logic [TOKEN_BITS-1:0] remainder_nxt,
  output logic                  waiting_nxt,
  output eval_res_t             res
);

  logic                  is_tick;
  logic [TIME_BITS-1:0]  ticks_inc;
  logic [TIME_BITS-1:0]  eval_ticks;
  logic [TOKEN_BITS-1:0] eval_amt;
  logic                  refill;
  logic [TOKEN_BITS-1:0] avail;
  logic                  fits;
  logic [TIME_BITS-1:0]  ticks_after;

  always_comb begin
    is_tick     = (req == REQ_TICK);
    ticks_inc   = (ticks != '1) ? ticks + 1'b1 : ticks;
    eval_ticks  = is_tick ? ticks_inc : ticks;
    eval_amt    = is_tick ? remainder : amount;
    refill      = (eval_ticks >= interval);
    avail       = refill ? refill_amount : token_count;
    ticks_after = refill ? '0 : eval_ticks;
    fits        = (eval_amt <= avail);

    token_count_nxt = token_count;
    ticks_nxt       = ticks;
    remainder_nxt   = remainder;
    waiting_nxt     = waiting;
    res             = '{has_result: 1'b0, status: ST_OK};

    if (is_tick) begin
      ticks_nxt = ticks_inc;
      if (waiting) begin
        // pending take re-evaluated with what it still needs
        ticks_nxt = ticks_after;
        if (fits) begin
          token_count_nxt = avail - eval_amt;
          remainder_nxt   = '0;
          waiting_nxt     = 1'b0;
          res             = '{has_result: 1'b1, status: ST_OK};
        end else begin
          remainder_nxt   = eval_amt - avail;
          token_count_nxt = '0;
        end
      end
    end else if (waiting) begin
      res = '{has_result: 1'b1, status: ST_BUSY};
    end else if (!may_wait) begin
      if (eval_amt > refill_amount) begin
        res = '{has_result: 1'b1, status: ST_TOO_BIG};
      end else begin
        ticks_nxt = ticks_after;
        if (fits) begin
          token_count_nxt = avail - eval_amt;
          res             = '{has_result: 1'b1, status: ST_OK};
        end else begin
          token_count_nxt = avail;
          res             = '{has_result: 1'b1, status: ST_UNAVAIL};
        end
      end
    end else begin
      ticks_nxt = ticks_after;
      if (fits) begin
        token_count_nxt = avail - eval_amt;
        res             = '{has_result: 1'b1, status: ST_OK};
      end else begin
        // drain the bucket, keep the rest for later ticks
        remainder_nxt   = eval_amt - avail;
        token_count_nxt = '0;
        waiting_nxt     = 1'b1;
      end
    end
  end

endmodule

FILE: hdl/windowed_token_rate_limiter.sv
// ----------------------------------------------------------------------------
// windowed_token_rate_limiter
// Token bucket refilled to full once a refill interval has passed.
// ----------------------------------------------------------------------------
// Each input word is either a time tick or a take request. A take is answered
// with a status and the tokens left; a blocking take that cannot be served
// drains the bucket and gets its answer on the tick that completes it, and a
// tick with nothing pending gives no result. The block takes one word per
// clock cycle while no untaken result holds it back: a word waits in the input
// register, is evaluated in a single pass of compare and subtract on the bucket
// state, and its result is registered in the output register. The refill check
// is done only when a take is evaluated, also on a tick with one pending.
// Writes to refill_amount also fill the bucket. Configuration must be written
// while no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module windowed_token_rate_limiter import wtrl_pkg::*; #(
  parameter int TOKEN_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [15:0] take_amount, [16] may_wait
  input  logic                      in_tuser,   // [0] req_type
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [15:0] tokens_left
  output logic [1:0]                out_tuser,  // [1:0] status
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  // input stage
  logic                   s1_valid;
  req_t                   s1_req;
  logic [AMOUNT_BITS-1:0] s1_amount;
  logic                   s1_may_wait;
  logic                   advance;

  // configuration registers
  logic [TIME_BITS-1:0]  interval_r, interval_nxt;
  logic [TOKEN_BITS-1:0] refill_amt_r, refill_amt_nxt;

  // bucket state
  logic [TOKEN_BITS-1:0] token_count_r, token_count_nxt;
  logic [TIME_BITS-1:0]  ticks_r, ticks_nxt;
  logic [TOKEN_BITS-1:0] remainder_r, remainder_nxt;
  logic                  waiting_r, waiting_nxt;

  // evaluator outputs
  logic [TOKEN_BITS-1:0] ev_token;
  logic [TIME_BITS-1:0]  ev_ticks;
  logic [TOKEN_BITS-1:0] ev_rem;
  logic                  ev_waiting;
  eval_res_t             ev_res;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r;
  logic [OUT_TDATA_BITS-1:0] out_tokens_r;

  wtrl_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (in_tuser),
    .in_amount   (in_tdata[AMOUNT_BITS-1:0]),
    .in_may_wait (in_tdata[AMOUNT_BITS]),
    .consume     (advance),
    .s1_valid    (s1_valid),
    .s1_req      (s1_req),
    .s1_amount   (s1_amount),
    .s1_may_wait (s1_may_wait)
  );

  wtrl_eval #(
    .TOKEN_BITS (TOKEN_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_eval (
    .req             (s1_req),
    .amount          (TOKEN_BITS'(s1_amount)),
    .may_wait        (s1_may_wait),
    .token_count     (token_count_r),
    .ticks           (ticks_r),
    .remainder       (remainder_r),
    .waiting         (waiting_r),
    .interval        (interval_r),
    .refill_amount   (refill_amt_r),
    .token_count_nxt (ev_token),
    .ticks_nxt       (ev_ticks),
    .remainder_nxt   (ev_rem),
    .waiting_nxt     (ev_waiting),
    .res             (ev_res)
  );

  // a word moves on unless its result would overwrite one not yet taken
  assign advance = s1_valid && (!ev_res.has_result || !out_valid_r || out_tready);

  always_comb begin
    interval_nxt    = interval_r;
    refill_amt_nxt  = refill_amt_r;
    token_count_nxt = token_count_r;
    ticks_nxt       = ticks_r;
    remainder_nxt   = remainder_r;
    waiting_nxt     = waiting_r;

    if (advance) begin
      token_count_nxt = ev_token;
      ticks_nxt       = ev_ticks;
      remainder_nxt   = ev_rem;
      waiting_nxt     = ev_waiting;
    end

    // register writes; writing the amount also fills the bucket
    if (cfg_we) begin
      case (cfg_addr)
        CFG_IDX_INTERVAL: begin
          interval_nxt = TIME_BITS'(cfg_wdata);
        end
        CFG_IDX_AMOUNT: begin
          refill_amt_nxt  = TOKEN_BITS'(cfg_wdata[AMOUNT_BITS-1:0]);
          token_count_nxt = TOKEN_BITS'(cfg_wdata[AMOUNT_BITS-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && ev_res.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= TIME_BITS'(RST_INTERVAL);
      refill_amt_r  <= TOKEN_BITS'(RST_AMOUNT);
      token_count_r <= TOKEN_BITS'(RST_AMOUNT);
      ticks_r       <= '0;
      remainder_r   <= '0;
      waiting_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      interval_r    <= interval_nxt;
      refill_amt_r  <= refill_amt_nxt;
      token_count_r <= token_count_nxt;
      ticks_r       <= ticks_nxt;
      remainder_r   <= remainder_nxt;
      waiting_r     <= waiting_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && ev_res.has_result) begin
      out_status_r <= ev_res.status;
      out_tokens_r <= OUT_TDATA_BITS'(ev_token);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tokens_r;
  assign out_tuser  = out_status_r;

  // a pending take always still needs tokens
  a_wait_needs_tokens: assert property (
    @(posedge clk) disable iff (!rst_n)
    waiting_r |-> (remainder_r != '0)
  ) else $error("waiting take with zero remainder");

  // a take answered busy leaves the bucket untouched
  a_busy_no_change: assert property (
    @(posedge clk) disable iff (!rst_n)
    (advance && s1_req == REQ_TAKE && waiting_r && !cfg_we)
      |=> ($stable(token_count_r) && $stable(ticks_r) && $stable(remainder_r))
  ) else $error("busy take changed bucket state");

  // a take that starts waiting has drained the bucket
  a_wait_drains: assert property (
    @(posedge clk) disable iff (!rst_n)
    (advance && ev_waiting && !waiting_r && !cfg_we) |=> (token_count_r == '0)
  ) else $error("waiting take left tokens in bucket");

endmodule

FILE: dv/wtrl_bucket_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wtrl_bucket_checker
// Bucket predictor and reply comparator for the windowed token rate limiter.
// ----------------------------------------------------------------------------
// Watches the input, result and configuration ports, keeps its own copy of the
// bucket state, queues the reply each accepted word should produce and checks
// every accepted reply against the oldest one queued.
// ----------------------------------------------------------------------------
module wtrl_bucket_checker import wtrl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [15:0] take_amount, [16] may_wait
  input  logic                      in_tuser,   // [0] req_type
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [OUT_TDATA_BITS-1:0] out_tdata,  // [15:0] tokens_left
  input  logic [1:0]                out_tuser,  // [1:0] status
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output int                        fail_count,
  output int                        replies_owed
);

  localparam int TICK_BITS = 32;

  typedef struct {
    status_t                status;
    logic [AMOUNT_BITS-1:0] tokens_left;
  } reply_t;

  logic [TICK_BITS-1:0]   interval_reg;
  logic [AMOUNT_BITS-1:0] amount_reg;
  logic [AMOUNT_BITS-1:0] bucket;
  logic [TICK_BITS-1:0]   ticks_elapsed;
  logic [AMOUNT_BITS-1:0] owed_tokens;
  logic                   take_parked;
  reply_t                 replies_due[$];
  int                     errors = 0;
  int                     owed_count = 0;

  assign fail_count   = errors;
  assign replies_owed = owed_count;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endfunction

  // lazy refill, only looked at when a take is evaluated or re-served on a tick
  function automatic void refill_if_due();
    if (ticks_elapsed >= interval_reg) begin
      bucket        = amount_reg;
      ticks_elapsed = '0;
    end
  endfunction

  // one pass of a blocking take, returns 1 when it completes
  function automatic bit serve_take(input logic [AMOUNT_BITS-1:0] want);
    refill_if_due();
    if (want <= bucket) begin
      bucket      = bucket - want;
      owed_tokens = '0;
      take_parked = 1'b0;
      return 1'b1;
    end
    owed_tokens = want - bucket;
    bucket      = '0;
    take_parked = 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_reply(input status_t st);
    reply_t r;
    r.status      = st;
    r.tokens_left = bucket;
    replies_due.push_back(r);
  endfunction

  function automatic void predict_word(input req_t kind, input logic [AMOUNT_BITS-1:0] want,
                                       input logic blocking);
    if (kind == REQ_TICK) begin
      if (ticks_elapsed != '1) ticks_elapsed = ticks_elapsed + 1'b1;
      if (take_parked && serve_take(owed_tokens)) push_reply(ST_OK);
    end else if (take_parked) begin
      push_reply(ST_BUSY);
    end else if (!blocking) begin
      if (want > amount_reg) begin
        push_reply(ST_TOO_BIG);
      end else begin
        refill_if_due();
        if (want <= bucket) begin
          bucket = bucket - want;
          push_reply(ST_OK);
        end else begin
          push_reply(ST_UNAVAIL);
        end
      end
    end else if (serve_take(want)) begin
      push_reply(ST_OK);
    end
  endfunction

  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst_n) begin
      interval_reg  = TICK_BITS'(RST_INTERVAL);
      amount_reg    = AMOUNT_BITS'(RST_AMOUNT);
      bucket        = AMOUNT_BITS'(RST_AMOUNT);
      ticks_elapsed = '0;
      owed_tokens   = '0;
      take_parked   = 1'b0;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          note_error($sformatf("unexpected reply status %0d tokens %0d", out_tuser, out_tdata));
        end else begin
          exp_r = replies_due.pop_front();
          if (out_tuser !== exp_r.status)
            note_error($sformatf("status expected %0d got %0d", exp_r.status, out_tuser));
          if (out_tdata !== exp_r.tokens_left)
            note_error($sformatf("tokens_left expected %0d got %0d",
                                 exp_r.tokens_left, out_tdata));
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_IDX_INTERVAL) begin
          interval_reg = cfg_wdata[TICK_BITS-1:0];
        end else if (cfg_addr == CFG_IDX_AMOUNT) begin
          amount_reg = cfg_wdata[AMOUNT_BITS-1:0];
          bucket     = cfg_wdata[AMOUNT_BITS-1:0];
        end
      end
      if (in_tvalid && in_tready)
        predict_word(req_t'(in_tuser), in_tdata[AMOUNT_BITS-1:0], in_tdata[AMOUNT_BITS]);
    end
    owed_count = replies_due.size();
  end

endmodule

FILE: dv/windowed_token_rate_limiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_token_rate_limiter_tb
// Stimulus and verdict for the windowed token rate limiter.
// ----------------------------------------------------------------------------
// A directed opening walks through the corner cases of takes and ticks (zero
// and oversized takes, busy replies, waiting takes completed by refills and
// by register writes), then random words run under several bucket settings
// and three flow-control patterns. The checker beside the block predicts and
// compares every reply; this module only drives words, registers and backpressure.
// ----------------------------------------------------------------------------
module windowed_token_rate_limiter_tb;
  import wtrl_pkg::*;

  localparam int STALL_LIMIT      = 2000;  // cycles with no word moving on either side
  localparam int RANDOM_PER_PHASE = 50;
  localparam int SETTLE_CYCLES    = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [15:0] take_amount, [16] may_wait
  logic                      in_tuser;   // [0] req_type
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [15:0] tokens_left
  logic [1:0]                out_tuser;  // [1:0] status
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_addr;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  int fail_count;
  int replies_owed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int cur_amount    = RST_AMOUNT;   // refill amount last written, shapes take sizes

  // settings used for the extreme phases, two per flow-control pattern
  logic [31:0] ext_interval [6] = '{32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd2};
  logic [15:0] ext_amount   [6] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF};

  always #4 clk = ~clk;

  windowed_token_rate_limiter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  wtrl_bucket_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: gives up once nothing has moved for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one word, with random idle cycles ahead of it; returns after the accepting edge
  task automatic send_word(input req_t kind, input logic [15:0] amt, input logic may_wait);
    logic [IN_TDATA_BITS-1:0] word;
    word                  = '0;
    word[AMOUNT_BITS-1:0] = amt;
    word[AMOUNT_BITS]     = may_wait;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending, wait for every owed reply, then let the pipeline empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a write to an unused index first, then both registers
  task automatic set_limits(input logic [31:0] new_interval, input logic [15:0] new_amount);
    cfg_we    <= 1'b1;
    cfg_addr  <= ($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_addr  <= CFG_IDX_INTERVAL;
    cfg_wdata <= new_interval;
    @(posedge clk);
    cfg_addr  <= CFG_IDX_AMOUNT;
    cfg_wdata <= 32'(new_amount);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_amount  = new_amount;
  endtask

  // mix of ticks, well-sized takes (a quarter blocking) and oversized noise
  task automatic random_items(input int count);
    int pick;
    int cap;
    cap = (cur_amount == 0) ? 3 : cur_amount + cur_amount / 2;
    if (cap > 65535) cap = 65535;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_word(REQ_TICK, 16'($urandom), 1'($urandom));
      else if (pick < 85)
        send_word(REQ_TAKE, 16'($urandom_range(0, cap)), ($urandom_range(0, 3) == 0));
      else
        send_word(REQ_TAKE, 16'($urandom), 1'b0);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_TICK;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_IDX_INTERVAL;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 55;

    // reset settings: full bucket of 100, long interval
    send_word(REQ_TAKE, 16'd0, 1'b0);       // zero take succeeds at once
    send_word(REQ_TAKE, 16'd100, 1'b0);     // empties the bucket
    send_word(REQ_TAKE, 16'd1, 1'b0);       // no refill yet, unavailable
    send_word(REQ_TAKE, 16'd101, 1'b0);     // above refill amount
    send_word(REQ_TAKE, 16'hFFFF, 1'b0);    // largest amount, non-blocking
    send_word(REQ_TAKE, 16'hFFFF, 1'b1);    // blocking take parks with all of it owed
    send_word(REQ_TAKE, 16'd5, 1'b0);       // busy while a take waits
    send_word(REQ_TAKE, 16'd0, 1'b1);       // busy, blocking flavor
    send_word(REQ_TICK, 16'hFFFF, 1'b1);    // tick too early to refill; fields ignored
    drain();

    // shortest interval, biggest bucket: the next tick finishes the parked take
    set_limits(32'd1, 16'hFFFF);
    send_word(REQ_TICK, 16'd0, 1'b0);
    send_word(REQ_TICK, 16'd0, 1'b0);       // nothing pending, no reply
    send_word(REQ_TAKE, 16'd0, 1'b1);
    send_word(REQ_TAKE, 16'hFFFF, 1'b0);
    send_word(REQ_TAKE, 16'd40000, 1'b1);
    drain();

    // empty bucket: blocking take waits until the amount is rewritten
    set_limits(32'd1, 16'd0);
    send_word(REQ_TAKE, 16'd1, 1'b0);
    send_word(REQ_TAKE, 16'd0, 1'b0);
    send_word(REQ_TAKE, 16'd5, 1'b1);
    send_word(REQ_TICK, 16'd0, 1'b0);       // refill to zero, still waiting
    drain();
    set_limits(32'hFFFF_FFFF, 16'd7);       // write fills the bucket, tick completes
    send_word(REQ_TICK, 16'd0, 1'b0);
    send_word(REQ_TAKE, 16'd9, 1'b1);       // parks with no refill ever due
    send_word(REQ_TICK, 16'hFFFF, 1'b1);
    drain();

    // random part: three flow-control patterns, four bucket settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        drain();
        if (sub % 2 == 0)
          set_limits(32'($urandom_range(1, 6)), 16'($urandom_range(1, 200)));
        else
          set_limits(ext_interval[mode * 2 + sub / 2], ext_amount[mode * 2 + sub / 2]);
        random_items(RANDOM_PER_PHASE);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
